/* rtl/core/tasp_pkg.sv */
// ----------------------------------------------------------------------------
// tasp_pkg
// Types and constants shared by the stick PD mixer core and its stages.
// ----------------------------------------------------------------------------
package tasp_pkg;

    typedef enum logic [1:0] {
        MODE_AIR       = 2'd0,
        MODE_CROSS     = 2'd1,
        MODE_SUBMERGED = 2'd2
    } mode_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ROLL_PROP   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROLL_RATE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_PROP = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_RATE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_THIRD_PROP  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_THIRD_RATE  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TILT_STEP   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_THR_GAIN    = 3'd7;

    // stick shaping, 13 bit so sums never wrap
    localparam logic [12:0] STICK_CENTER = 13'd1500;
    localparam logic [12:0] STICK_MIN    = 13'd1000;
    localparam logic [12:0] STICK_MAX    = 13'd2000;
    localparam logic [12:0] DEAD_WIDE    = 13'd50;
    localparam logic [12:0] DEAD_NARROW  = 13'd20;

    // throttle
    localparam logic [11:0] THR_TRANS      = 12'd1850;
    localparam logic [11:0] THR_BASE       = 12'd1200;
    localparam logic [11:0] THR_GATE_HIGH  = 12'd1950;
    localparam logic [17:0] THR_SAT_PROD   = 18'd70000;
    localparam int          THR_RECIP_SHIFT = 32;
    localparam longint unsigned THR_DIV_WIDE = 64'd4375;
    localparam longint unsigned THR_RECIP_FULL =
        ((64'd1 << THR_RECIP_SHIFT) + THR_DIV_WIDE - 64'd1) / THR_DIV_WIDE;
    localparam logic [19:0] THR_RECIP = THR_RECIP_FULL[19:0];
    localparam logic [12:0] THR_DIV   = THR_DIV_WIDE[12:0];

    // tilt
    localparam logic [11:0] TILT_BAND_LOW  = 12'd1400;
    localparam logic [11:0] TILT_BAND_HIGH = 12'd1600;
    localparam logic [11:0] TILT_MIN       = 12'd1000;
    localparam logic [11:0] TILT_MAX       = 12'd2000;
    localparam logic [10:0] TILT_CENTER    = 11'd1500;
    localparam logic [10:0] TILT_RESET     = 11'd1000;

    localparam logic signed [19:0] CMD_LIMIT = 20'sd1000;

    typedef struct packed {
        logic [15:0] roll_prop;
        logic [15:0] roll_rate;
        logic [15:0] second_prop;
        logic [15:0] second_rate;
        logic [15:0] third_prop;
        logic [15:0] third_rate;
        logic [7:0]  tilt_step;
        logic [7:0]  thr_gain;
    } cfg_t;

    typedef struct packed {
        logic [11:0]        mode_switch_pulse;
        logic [11:0]        throttle_pulse;
        logic [11:0]        roll_pulse;
        logic [11:0]        second_pulse;
        logic [11:0]        third_pulse;
        logic [11:0]        tilt_pulse;
        logic signed [15:0] gyro_x_rate;
        logic signed [15:0] gyro_y_rate;
        logic signed [15:0] gyro_z_rate;
    } item_t;

    typedef struct packed {
        mode_t              mode;
        logic [17:0]        thr_prod;
        logic signed [9:0]  roll_d;
        logic signed [9:0]  second_d;
        logic signed [9:0]  third_d;
        logic signed [15:0] roll_rate;
        logic signed [15:0] second_rate;
        logic signed [15:0] third_rate;
        logic signed [9:0]  tilt_cmd;
    } front_t;

    typedef struct packed {
        mode_t              mode;
        logic               thr_sat;
        logic [28:0]        thr_num;
        logic [16:0]        thr_q0;
        logic signed [39:0] roll_v;
        logic signed [39:0] second_v;
        logic signed [39:0] third_v;
        logic signed [9:0]  tilt_cmd;
    } prod_t;

    function automatic logic signed [9:0] shape_stick(input logic [11:0] pulse,
                                                      input logic [12:0] dead);
        logic [12:0] p;
        logic [12:0] d;
        logic        keep;
        p    = {1'b0, pulse};
        d    = p - STICK_CENTER;
        keep = (p >= STICK_CENTER + dead && p <= STICK_MAX) ||
               (p >= STICK_MIN && p + dead <= STICK_CENTER);
        return keep ? $signed(d[9:0]) : 10'sd0;
    endfunction

endpackage

/* rtl/core/tasp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tasp_cfg_regs
// Gain, slew and throttle scale registers with their reset values.
// ----------------------------------------------------------------------------
module tasp_cfg_regs
    import tasp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.roll_prop   <= 16'd256;
            cfg_reg.roll_rate   <= 16'd0;
            cfg_reg.second_prop <= 16'd256;
            cfg_reg.second_rate <= 16'd0;
            cfg_reg.third_prop  <= 16'd256;
            cfg_reg.third_rate  <= 16'd0;
            cfg_reg.tilt_step   <= 8'd1;
            cfg_reg.thr_gain    <= 8'd80;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROLL_PROP:   cfg_reg.roll_prop   <= cfg_wdata;
                REG_ROLL_RATE:   cfg_reg.roll_rate   <= cfg_wdata;
                REG_SECOND_PROP: cfg_reg.second_prop <= cfg_wdata;
                REG_SECOND_RATE: cfg_reg.second_rate <= cfg_wdata;
                REG_THIRD_PROP:  cfg_reg.third_prop  <= cfg_wdata;
                REG_THIRD_RATE:  cfg_reg.third_rate  <= cfg_wdata;
                REG_TILT_STEP:   cfg_reg.tilt_step   <= cfg_wdata[7:0];
                REG_THR_GAIN:    cfg_reg.thr_gain    <= cfg_wdata[7:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/tasp_front_stage.sv */
// ----------------------------------------------------------------------------
// tasp_front_stage
// Mode select, gyro low-pass filters, tilt ramp, stick shaping and the
// throttle product; holds the per-tick state.
// ----------------------------------------------------------------------------
module tasp_front_stage
    import tasp_pkg::*;
#(
    parameter int LOW_BAND_MIN      = 900,
    parameter int LOW_BAND_MAX      = 1300,
    parameter int HIGH_BAND_MIN     = 1700,
    parameter int HIGH_BAND_MAX     = 2100,
    parameter int SLOW_FILTER_ALPHA = 65014,
    parameter int FAST_FILTER_ALPHA = 65535
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  logic   advance,
    input  item_t  item,
    input  cfg_t   cfg,
    output front_t front
);

    localparam logic [11:0] LB_MIN  = 12'(LOW_BAND_MIN);
    localparam logic [11:0] LB_MAX  = 12'(LOW_BAND_MAX);
    localparam logic [11:0] HB_MIN  = 12'(HIGH_BAND_MIN);
    localparam logic [11:0] HB_MAX  = 12'(HIGH_BAND_MAX);
    localparam logic [15:0] SLOW_A  = 16'(SLOW_FILTER_ALPHA);
    localparam logic [15:0] FAST_A  = 16'(FAST_FILTER_ALPHA);

    mode_t              mode_reg;
    mode_t              mode_next;
    logic [10:0]        tilt_reg;
    logic [10:0]        tilt_next;
    logic signed [15:0] gy_filt_reg;
    logic signed [15:0] gy_filt_next;
    logic signed [15:0] gz_filt_reg;
    logic signed [15:0] gz_filt_next;
    front_t             front_reg;
    front_t             front_next;

    logic [10:0]        tilt_target;
    logic [11:0]        tilt_up;
    logic [11:0]        tilt_down;
    logic [11:0]        tilt_ofs;
    logic               thr_active;
    logic [11:0]        thr_diff;
    logic [17:0]        thr_prod;

    function automatic logic signed [15:0] lowpass(input logic signed [15:0] f,
                                                   input logic signed [15:0] x,
                                                   input logic [15:0]        alpha);
        logic signed [16:0] diff;
        logic signed [33:0] prod;
        logic signed [17:0] sum;
        diff = $signed({x[15], x}) - $signed({f[15], f});
        prod = diff * $signed({1'b0, alpha}) + 34'sd32768;
        sum  = $signed({{2{f[15]}}, f}) + $signed(prod[33:16]);
        return sum[15:0];
    endfunction

    always_comb
    begin
        mode_next = mode_reg;
        if (item.mode_switch_pulse > LB_MIN && item.mode_switch_pulse < LB_MAX)
        begin
            mode_next = (item.throttle_pulse < THR_TRANS) ? MODE_AIR : MODE_CROSS;
        end
        else if (item.mode_switch_pulse > HB_MIN && item.mode_switch_pulse < HB_MAX)
        begin
            mode_next = MODE_SUBMERGED;
        end

        gy_filt_next = lowpass(gy_filt_reg, item.gyro_y_rate, SLOW_A);
        gz_filt_next = lowpass(gz_filt_reg, item.gyro_z_rate, FAST_A);

        if (item.tilt_pulse > TILT_BAND_LOW && item.tilt_pulse < TILT_BAND_HIGH)
        begin
            tilt_target = TILT_CENTER;
        end
        else if (item.tilt_pulse < TILT_MIN || item.tilt_pulse > TILT_MAX)
        begin
            tilt_target = TILT_CENTER;
        end
        else
        begin
            tilt_target = item.tilt_pulse[10:0];
        end

        tilt_up   = {1'b0, tilt_reg} + {4'b0, cfg.tilt_step};
        tilt_down = {1'b0, tilt_reg} - {4'b0, cfg.tilt_step};
        if (tilt_reg < tilt_target)
        begin
            tilt_next = (tilt_up > {1'b0, tilt_target}) ? tilt_target : tilt_up[10:0];
        end
        else if (tilt_reg > tilt_target)
        begin
            tilt_next = (tilt_down < {1'b0, tilt_target}) ? tilt_target : tilt_down[10:0];
        end
        else
        begin
            tilt_next = tilt_reg;
        end
        tilt_ofs = {1'b0, tilt_next} - {1'b0, TILT_CENTER};

        // gated pulses below the base give zero, so only base..gate high drives
        thr_active = item.throttle_pulse >= THR_BASE && item.throttle_pulse <= THR_GATE_HIGH;
        thr_diff   = item.throttle_pulse - THR_BASE;
        thr_prod   = thr_active ? thr_diff[9:0] * cfg.thr_gain : 18'd0;

        front_next.mode        = mode_next;
        front_next.thr_prod    = thr_prod;
        front_next.roll_d      = shape_stick(item.roll_pulse, DEAD_WIDE);
        front_next.second_d    = shape_stick(item.second_pulse, DEAD_WIDE);
        front_next.third_d     = shape_stick(item.third_pulse, DEAD_NARROW);
        front_next.roll_rate   = item.gyro_x_rate;
        front_next.second_rate = gy_filt_next;
        front_next.third_rate  = gz_filt_next;
        front_next.tilt_cmd    = $signed(tilt_ofs[9:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_AIR;
            tilt_reg    <= TILT_RESET;
            gy_filt_reg <= 16'sd0;
            gz_filt_reg <= 16'sd0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            tilt_reg    <= tilt_next;
            gy_filt_reg <= gy_filt_next;
            gz_filt_reg <= gz_filt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

/* rtl/core/tasp_product_stage.sv */
// ----------------------------------------------------------------------------
// tasp_product_stage
// PD products for the three axes and the reciprocal estimate of the
// throttle quotient.
// ----------------------------------------------------------------------------
module tasp_product_stage
    import tasp_pkg::*;
(
    input  logic   clk,
    input  logic   load,
    input  front_t front,
    input  cfg_t   cfg,
    output prod_t  prod
);

    prod_t       prod_reg;
    prod_t       prod_next;
    logic [48:0] recip_prod;

    function automatic logic signed [39:0] pd_sum(input logic signed [9:0]  d,
                                                  input logic [15:0]        kp,
                                                  input logic signed [15:0] rate,
                                                  input logic [15:0]        kd);
        logic signed [26:0] p;
        logic signed [32:0] r;
        p = d * $signed({1'b0, kp});
        r = rate * $signed({1'b0, kd});
        return $signed({p[26], p, 12'b0}) - $signed({{7{r[32]}}, r});
    endfunction

    always_comb
    begin
        prod_next.mode     = front.mode;
        prod_next.tilt_cmd = front.tilt_cmd;
        prod_next.thr_sat  = front.thr_prod >= THR_SAT_PROD;
        prod_next.thr_num  = {front.thr_prod[16:0], 12'b0};
        recip_prod         = prod_next.thr_num * THR_RECIP;
        prod_next.thr_q0   = recip_prod[THR_RECIP_SHIFT +: 17];
        prod_next.roll_v   = pd_sum(front.roll_d, cfg.roll_prop,
                                    front.roll_rate, cfg.roll_rate);
        prod_next.second_v = pd_sum(front.second_d, cfg.second_prop,
                                    front.second_rate, cfg.second_rate);
        prod_next.third_v  = pd_sum(front.third_d, cfg.third_prop,
                                    front.third_rate, cfg.third_rate);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

/* rtl/core/tasp_result_stage.sv */
// ----------------------------------------------------------------------------
// tasp_result_stage
// Quotient correction, axis scaling and saturation, mode gating; holds the
// result register.
// ----------------------------------------------------------------------------
module tasp_result_stage
    import tasp_pkg::*;
(
    input  logic               clk,
    input  logic               load,
    input  prod_t              prod,
    output logic [1:0]         vehicle_mode,
    output logic [15:0]        throttle_cmd,
    output logic signed [10:0] roll_cmd,
    output logic signed [10:0] second_cmd,
    output logic signed [10:0] third_cmd,
    output logic signed [9:0]  tilt_cmd
);

    logic [1:0]         mode_reg;
    logic [15:0]        throttle_reg;
    logic signed [10:0] roll_reg;
    logic signed [10:0] second_reg;
    logic signed [10:0] third_reg;
    logic signed [9:0]  tilt_reg;

    logic [29:0]        thr_back;
    logic [16:0]        thr_q;
    logic [15:0]        throttle_next;
    logic               under;

    function automatic logic signed [10:0] sat_cmd(input logic signed [39:0] v,
                                                   input logic               en);
        logic signed [19:0] q;
        q = v[39:20];
        if (!en)
        begin
            return 11'sd0;
        end
        else if (q > CMD_LIMIT)
        begin
            return 11'sd1000;
        end
        else if (q < -CMD_LIMIT)
        begin
            return -11'sd1000;
        end
        else
        begin
            return q[10:0];
        end
    endfunction

    always_comb
    begin
        thr_back      = prod.thr_q0 * THR_DIV;
        thr_q         = (thr_back > {1'b0, prod.thr_num}) ? prod.thr_q0 - 17'd1 : prod.thr_q0;
        throttle_next = prod.thr_sat ? 16'hFFFF : thr_q[15:0];
        under         = prod.mode == MODE_SUBMERGED;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mode_reg     <= prod.mode;
            throttle_reg <= throttle_next;
            roll_reg     <= sat_cmd(prod.roll_v, under);
            second_reg   <= sat_cmd(prod.second_v, under);
            third_reg    <= sat_cmd(prod.third_v, under);
            tilt_reg     <= prod.tilt_cmd;
        end
    end

    assign vehicle_mode = mode_reg;
    assign throttle_cmd = throttle_reg;
    assign roll_cmd     = roll_reg;
    assign second_cmd   = second_reg;
    assign third_cmd    = third_reg;
    assign tilt_cmd     = tilt_reg;

endmodule

/* rtl/core/three_axis_stick_pd_mixer_core.sv */
// ----------------------------------------------------------------------------
// three_axis_stick_pd_mixer_core
// Per-tick RC stick and gyro mixer: mode, throttle, three PD axes and tilt.
//
// One input item carries six RC pulse widths and three gyro rates; one result
// item carries mode, throttle, three axis drives and the tilt offset. Both
// channels use valid/ready. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_wdata); the user must write it only while the core is idle (not enforced).
// The core is a four-register pipeline: input register, state/filter stage,
// product stage and result register. An accepted item moves through each
// register in that order; one item per cycle sustained unless the receiver
// stalls, set by the single pass through the stages with one multiplier deep each.
// Mode, tilt position and gyro filters update when an item leaves the input
// register, so results follow input order.
// Reset clears all valid bits, sets fly mode, tilt at 1000, filters at zero
// and the configuration registers to their defaults.
// When the receiver stalls, each stage holds and in_ready drops only once
// every stage holds an item.
// ----------------------------------------------------------------------------
module three_axis_stick_pd_mixer_core
    import tasp_pkg::*;
#(
    parameter int LOW_BAND_MIN      = 900,
    parameter int LOW_BAND_MAX      = 1300,
    parameter int HIGH_BAND_MIN     = 1700,
    parameter int HIGH_BAND_MAX     = 2100,
    parameter int SLOW_FILTER_ALPHA = 65014,
    parameter int FAST_FILTER_ALPHA = 65535
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [11:0]            mode_switch_pulse,
    input  logic [11:0]            throttle_pulse,
    input  logic [11:0]            roll_pulse,
    input  logic [11:0]            second_pulse,
    input  logic [11:0]            third_pulse,
    input  logic [11:0]            tilt_pulse,
    input  logic signed [15:0]     gyro_x_rate,
    input  logic signed [15:0]     gyro_y_rate,
    input  logic signed [15:0]     gyro_z_rate,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             vehicle_mode,
    output logic [15:0]            throttle_cmd,
    output logic signed [10:0]     roll_cmd,
    output logic signed [10:0]     second_cmd,
    output logic signed [10:0]     third_cmd,
    output logic signed [9:0]      tilt_cmd,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t   cfg;
    item_t  item_in;
    item_t  item_reg;
    front_t front;
    prod_t  prod;

    logic in_valid_reg;
    logic front_valid_reg;
    logic prod_valid_reg;
    logic out_valid_reg;
    logic en_in;
    logic en_front;
    logic en_prod;
    logic en_out;

    assign en_out   = !out_valid_reg || out_ready;
    assign en_prod  = !prod_valid_reg || en_out;
    assign en_front = !front_valid_reg || en_prod;
    assign en_in    = !in_valid_reg || en_front;
    assign in_ready = en_in;
    assign out_valid = out_valid_reg;

    assign item_in.mode_switch_pulse = mode_switch_pulse;
    assign item_in.throttle_pulse    = throttle_pulse;
    assign item_in.roll_pulse        = roll_pulse;
    assign item_in.second_pulse      = second_pulse;
    assign item_in.third_pulse       = third_pulse;
    assign item_in.tilt_pulse        = tilt_pulse;
    assign item_in.gyro_x_rate       = gyro_x_rate;
    assign item_in.gyro_y_rate       = gyro_y_rate;
    assign item_in.gyro_z_rate       = gyro_z_rate;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            front_valid_reg <= 1'b0;
            prod_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (en_in)
            begin
                in_valid_reg <= in_valid;
            end
            if (en_front)
            begin
                front_valid_reg <= in_valid_reg;
            end
            if (en_prod)
            begin
                prod_valid_reg <= front_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_in)
        begin
            item_reg <= item_in;
        end
    end

    tasp_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tasp_front_stage
    #(
        .LOW_BAND_MIN      (LOW_BAND_MIN),
        .LOW_BAND_MAX      (LOW_BAND_MAX),
        .HIGH_BAND_MIN     (HIGH_BAND_MIN),
        .HIGH_BAND_MAX     (HIGH_BAND_MAX),
        .SLOW_FILTER_ALPHA (SLOW_FILTER_ALPHA),
        .FAST_FILTER_ALPHA (FAST_FILTER_ALPHA)
    )
    u_front_stage
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (en_front),
        .advance (en_front && in_valid_reg),
        .item    (item_reg),
        .cfg     (cfg),
        .front   (front)
    );

    tasp_product_stage u_product_stage
    (
        .clk   (clk),
        .load  (en_prod),
        .front (front),
        .cfg   (cfg),
        .prod  (prod)
    );

    tasp_result_stage u_result_stage
    (
        .clk          (clk),
        .load         (en_out),
        .prod         (prod),
        .vehicle_mode (vehicle_mode),
        .throttle_cmd (throttle_cmd),
        .roll_cmd     (roll_cmd),
        .second_cmd   (second_cmd),
        .third_cmd    (third_cmd),
        .tilt_cmd     (tilt_cmd)
    );

endmodule

/* tb/three_axis_stick_pd_mixer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_stick_pd_mixer_core testbench
// Drives control ticks through the mixer core on valid/ready and tracks the
// mode, throttle gate, the three PD axes with their gyro filters and the tilt
// ramp in a cycle-free copy of the core. Every command item that comes out is
// compared with the oldest tracked tick. A directed set of edge ticks runs
// first, then random ticks over several register settings and idling patterns.
// ----------------------------------------------------------------------------
module testbench;
    import tasp_pkg::*;

    localparam int LOW_MIN     = 900;
    localparam int LOW_MAX     = 1300;
    localparam int HIGH_MIN    = 1700;
    localparam int HIGH_MAX    = 2100;
    localparam int SLOW_ALPHA  = 65014;
    localparam int FAST_ALPHA  = 65535;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_TICKS = 91;
    localparam int REG_COUNT   = 8;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum {CFG_MODERATE, CFG_MAX, CFG_ZERO, CFG_WIDE, CFG_MIXED} cfg_style_t;

    typedef struct packed {
        mode_t              mode;
        logic [15:0]        throttle;
        logic signed [10:0] roll;
        logic signed [10:0] second;
        logic signed [10:0] third;
        logic signed [9:0]  tilt;
    } mix_cmds_t;

    class pd_mix_tracker;
        logic [15:0] roll_prop, roll_rate, second_prop, second_rate;
        logic [15:0] third_prop, third_rate;
        logic [7:0]  tilt_step, thr_gain;
        mode_t       mode;
        int          tilt_pos;
        int          filt_y;
        int          filt_z;
        mix_cmds_t   pending_cmds[$];
        int          errors;

        function new();
            roll_prop   = 16'd256;
            roll_rate   = 16'd0;
            second_prop = 16'd256;
            second_rate = 16'd0;
            third_prop  = 16'd256;
            third_rate  = 16'd0;
            tilt_step   = 8'd1;
            thr_gain    = 8'd80;
            mode        = MODE_AIR;
            tilt_pos    = 1000;
            filt_y      = 0;
            filt_z      = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ROLL_PROP:   roll_prop   = data;
                REG_ROLL_RATE:   roll_rate   = data;
                REG_SECOND_PROP: second_prop = data;
                REG_SECOND_RATE: second_rate = data;
                REG_THIRD_PROP:  third_prop  = data;
                REG_THIRD_RATE:  third_rate  = data;
                REG_TILT_STEP:   tilt_step   = data[7:0];
                REG_THR_GAIN:    thr_gain    = data[7:0];
                default: ;
            endcase
        endfunction

        function int shape(int pulse, int dead);
            int d;
            d = pulse - 1500;
            if (d < dead && d > -dead)
                return 0;
            if (d > 500 || d < -500)
                return 0;
            return d;
        endfunction

        function int lowpass(int f, int x, int alpha);
            longint prod;
            prod = longint'(x - f) * longint'(alpha) + 64'sd32768;
            return f + int'(prod >>> 16);
        endfunction

        function int pd_drive(int d, logic [15:0] kp, int rate, logic [15:0] kd);
            longint v;
            longint q;
            v = longint'(d) * longint'(kp) * 64'sd4096 - longint'(rate) * longint'(kd);
            q = v >>> 20;
            if (q > 1000)
                q = 1000;
            if (q < -1000)
                q = -1000;
            return int'(q);
        endfunction

        function void note_tick(item_t t);
            int        sw, thr, tilt_in, target;
            longint    num, thr_out;
            int        roll_o, second_o, third_o;
            mix_cmds_t c;
            sw       = int'(t.mode_switch_pulse);
            thr      = int'(t.throttle_pulse);
            tilt_in  = int'(t.tilt_pulse);
            roll_o   = 0;
            second_o = 0;
            third_o  = 0;
            thr_out  = 0;

            if (sw > LOW_MIN && sw < LOW_MAX)
                mode = (thr < 1850) ? MODE_AIR : MODE_CROSS;
            else if (sw > HIGH_MIN && sw < HIGH_MAX)
                mode = MODE_SUBMERGED;

            if ((thr < 1150 && thr > 1050) || thr < 1050 || thr > 1950)
                thr = 0;
            if (thr >= 1200)
            begin
                num     = longint'(thr - 1200) * longint'(thr_gain) * 64'sd65536;
                thr_out = num / 64'sd70000;
                if (thr_out > 65535)
                    thr_out = 65535;
            end

            filt_y = lowpass(filt_y, int'($signed(t.gyro_y_rate)), SLOW_ALPHA);
            filt_z = lowpass(filt_z, int'($signed(t.gyro_z_rate)), FAST_ALPHA);

            if (mode == MODE_SUBMERGED)
            begin
                roll_o   = pd_drive(shape(int'(t.roll_pulse), 50), roll_prop,
                                    int'($signed(t.gyro_x_rate)), roll_rate);
                second_o = pd_drive(shape(int'(t.second_pulse), 50), second_prop,
                                    filt_y, second_rate);
                third_o  = pd_drive(shape(int'(t.third_pulse), 20), third_prop,
                                    filt_z, third_rate);
            end

            if (tilt_in < 1600 && tilt_in > 1400)
                target = 1500;
            else if (tilt_in < 1000 || tilt_in > 2000)
                target = 1500;
            else
                target = tilt_in;

            if (tilt_pos < target)
            begin
                tilt_pos += int'(tilt_step);
                if (tilt_pos > target)
                    tilt_pos = target;
            end
            else if (tilt_pos > target)
            begin
                tilt_pos -= int'(tilt_step);
                if (tilt_pos < target)
                    tilt_pos = target;
            end

            c.mode     = mode;
            c.throttle = 16'(thr_out);
            c.roll     = 11'(roll_o);
            c.second   = 11'(second_o);
            c.third    = 11'(third_o);
            c.tilt     = 10'(tilt_pos - 1500);
            pending_cmds.push_back(c);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_cmds(mix_cmds_t got);
            mix_cmds_t want;
            if (pending_cmds.size() == 0)
            begin
                $error("command item with no tick waiting");
                errors++;
                return;
            end
            want = pending_cmds.pop_front();
            compare_field("vehicle_mode", longint'(want.mode), longint'(got.mode));
            compare_field("throttle_cmd", longint'(want.throttle), longint'(got.throttle));
            compare_field("roll_cmd", longint'($signed(want.roll)), longint'($signed(got.roll)));
            compare_field("second_cmd", longint'($signed(want.second)),
                          longint'($signed(got.second)));
            compare_field("third_cmd", longint'($signed(want.third)),
                          longint'($signed(got.third)));
            compare_field("tilt_cmd", longint'($signed(want.tilt)), longint'($signed(got.tilt)));
        endfunction

        function int pending();
            return pending_cmds.size();
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    item_t                  tick_bus  = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [1:0]             vehicle_mode;
    logic [15:0]            throttle_cmd;
    logic signed [10:0]     roll_cmd;
    logic signed [10:0]     second_cmd;
    logic signed [10:0]     third_cmd;
    logic signed [9:0]      tilt_cmd;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          idle_cycles    = 0;
    pd_mix_tracker mix;

    logic [CFG_INDEX_W-1:0] reg_order[REG_COUNT] = '{REG_ROLL_PROP, REG_ROLL_RATE,
        REG_SECOND_PROP, REG_SECOND_RATE, REG_THIRD_PROP, REG_THIRD_RATE,
        REG_TILT_STEP, REG_THR_GAIN};
    idle_mode_t phase_idling[PHASE_COUNT] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER,
        IDLE_BOTH, IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
    cfg_style_t phase_style[PHASE_COUNT] = '{CFG_MODERATE, CFG_MAX, CFG_ZERO, CFG_WIDE,
        CFG_MODERATE, CFG_MIXED, CFG_MODERATE, CFG_MIXED};

    three_axis_stick_pd_mixer_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mode_switch_pulse (tick_bus.mode_switch_pulse),
        .throttle_pulse    (tick_bus.throttle_pulse),
        .roll_pulse        (tick_bus.roll_pulse),
        .second_pulse      (tick_bus.second_pulse),
        .third_pulse       (tick_bus.third_pulse),
        .tilt_pulse        (tick_bus.tilt_pulse),
        .gyro_x_rate       (tick_bus.gyro_x_rate),
        .gyro_y_rate       (tick_bus.gyro_y_rate),
        .gyro_z_rate       (tick_bus.gyro_z_rate),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .vehicle_mode      (vehicle_mode),
        .throttle_cmd      (throttle_cmd),
        .roll_cmd          (roll_cmd),
        .second_cmd        (second_cmd),
        .third_cmd         (third_cmd),
        .tilt_cmd          (tilt_cmd),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        mix_cmds_t seen;
        seen.mode     = mode_t'(vehicle_mode);
        seen.throttle = throttle_cmd;
        seen.roll     = roll_cmd;
        seen.second   = second_cmd;
        seen.third    = third_cmd;
        seen.tilt     = tilt_cmd;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                mix.note_tick(tick_bus);
            if (out_valid && out_ready)
                mix.check_cmds(seen);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("three_axis_stick_pd_mixer_core test failed");
        $finish;
    end

    function automatic item_t make_tick(int sw, int thr, int roll, int second, int third,
                                        int tilt, int gx, int gy, int gz);
        item_t t;
        t.mode_switch_pulse = 12'(sw);
        t.throttle_pulse    = 12'(thr);
        t.roll_pulse        = 12'(roll);
        t.second_pulse      = 12'(second);
        t.third_pulse       = 12'(third);
        t.tilt_pulse        = 12'(tilt);
        t.gyro_x_rate       = 16'(gx);
        t.gyro_y_rate       = 16'(gy);
        t.gyro_z_rate       = 16'(gz);
        return t;
    endfunction

    function automatic int random_stick();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return $urandom_range(4095);
        if (r < 25)
            return $urandom_range(1440, 1560);
        return $urandom_range(950, 2050);
    endfunction

    function automatic int random_gyro();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return -32768;
        if (r < 10)
            return 32767;
        if (r < 30)
            return $urandom_range(8000) - 4000;
        return int'($signed(16'($urandom)));
    endfunction

    function automatic item_t random_tick();
        int sw_marks[4]   = '{LOW_MIN, LOW_MAX, HIGH_MIN, HIGH_MAX};
        int thr_marks[11] = '{1049, 1050, 1051, 1149, 1150, 1199, 1200, 1849, 1850,
                              1950, 1951};
        int r, sw, thr, tilt;
        r = $urandom_range(99);
        if (r < 45)
            sw = $urandom_range(HIGH_MIN + 1, HIGH_MAX - 1);
        else if (r < 70)
            sw = $urandom_range(LOW_MIN + 1, LOW_MAX - 1);
        else if (r < 80)
            sw = sw_marks[$urandom_range(3)];
        else
            sw = $urandom_range(4095);
        r = $urandom_range(99);
        if (r < 15)
            thr = $urandom_range(4095);
        else if (r < 25)
            thr = thr_marks[$urandom_range(10)];
        else
            thr = $urandom_range(1000, 2000);
        tilt = ($urandom_range(99) < 15) ? $urandom_range(4095) : $urandom_range(950, 2050);
        return make_tick(sw, thr, random_stick(), random_stick(), random_stick(), tilt,
                         random_gyro(), random_gyro(), random_gyro());
    endfunction

    function automatic logic [15:0] pick_reg_value(logic [CFG_INDEX_W-1:0] idx,
                                                   cfg_style_t style);
        logic [15:0] full;
        cfg_style_t  s;
        full = (idx == REG_TILT_STEP || idx == REG_THR_GAIN) ? 16'h00FF : 16'hFFFF;
        s    = style;
        if (s == CFG_MIXED)
            s = ($urandom_range(2) == 0) ? CFG_ZERO :
                ($urandom_range(1) == 0) ? CFG_MAX : CFG_MODERATE;
        case (s)
            CFG_MAX:  return full;
            CFG_ZERO: return 16'd0;
            CFG_WIDE: return 16'($urandom_range(full));
            default:
                case (idx)
                    REG_TILT_STEP: return 16'($urandom_range(1, 60));
                    REG_THR_GAIN:  return 16'($urandom_range(40, 200));
                    REG_ROLL_RATE, REG_SECOND_RATE, REG_THIRD_RATE:
                        return 16'($urandom_range(8192));
                    default:       return 16'($urandom_range(64, 1024));
                endcase
        endcase
    endfunction

    task automatic write_settings(cfg_style_t style);
        logic [15:0] v;
        logic [15:0] data;
        for (int pos = 0; pos < REG_COUNT; pos++)
        begin
            v = pick_reg_value(reg_order[pos], style);
            // put junk in the upper byte of narrow registers
            if (reg_order[pos] == REG_TILT_STEP || reg_order[pos] == REG_THR_GAIN)
                data = {8'($urandom_range(255)), v[7:0]};
            else
                data = v;
            cfg_we    <= 1'b1;
            cfg_index <= reg_order[pos];
            cfg_wdata <= data;
            @(posedge clk);
            mix.write_reg(reg_order[pos], data);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(idle_mode_t m);
        send_idle_pct  = (m == IDLE_SENDER) ? 47 : (m == IDLE_BOTH) ? 14 : 0;
        recv_stall_pct = (m == IDLE_RECEIVER) ? 47 : (m == IDLE_BOTH) ? 14 : 0;
    endtask

    task automatic send_tick(item_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        tick_bus <= t;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (mix.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(4095, 4095, 4095, 4095, 4095, 4095, -1, -1, -1));
        send_tick(make_tick(1100, 1849, 1500, 1500, 1500, 1400, 32767, 32767, 32767));
        send_tick(make_tick(1100, 1850, 2000, 1000, 2000, 1401, 0, 0, 0));
        send_tick(make_tick(LOW_MIN, 1500, 1800, 1800, 1800, 1599, 100, 100, 100));
        send_tick(make_tick(LOW_MAX, 1500, 1800, 1800, 1800, 1600, 100, 100, 100));
        send_tick(make_tick(HIGH_MIN, 1500, 1800, 1800, 1800, 999, 100, 100, 100));
        send_tick(make_tick(HIGH_MIN + 1, 1200, 1000, 2000, 1520, 2000,
                            -32768, -32768, -32768));
        send_tick(make_tick(HIGH_MAX - 1, 1201, 1549, 1451, 1519, 1000,
                            32767, 32767, 32767));
        send_tick(make_tick(HIGH_MAX, 1050, 1550, 1450, 1481, 2001, 0, 0, 0));
        send_tick(make_tick(1800, 1051, 1451, 1550, 1480, 2000, -32768, 32767, -32768));
        send_tick(make_tick(1800, 1149, 999, 2001, 1000, 1700, 5000, -5000, 5000));
        send_tick(make_tick(1800, 1150, 2000, 1000, 2001, 1300, 0, 0, 0));
        send_tick(make_tick(1800, 1199, 1450, 1549, 1500, 4095, 1, -1, 1));
        send_tick(make_tick(1800, 1950, 4095, 0, 4095, 2000, 12345, -12345, 20000));
        send_tick(make_tick(1800, 1951, 1550, 1550, 1520, 2000, -20000, 20000, -1));
        send_tick(make_tick(1800, 1049, 1001, 1999, 1021, 1000, 300, 300, 300));
        send_tick(make_tick(1250, 1849, 1800, 1200, 1700, 1800, 0, 0, 0));
        send_tick(make_tick(1000, 2000, 1800, 1200, 1700, 1800, 0, 0, 0));
        send_tick(make_tick(2000, 1575, 1800, 1200, 1700, 1800, -7, 7, -7));
    endtask

    initial
    begin
        mix = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idling(IDLE_NONE);
        run_directed();
        drain();
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            write_settings(phase_style[phase]);
            set_idling(phase_idling[phase]);
            repeat (PHASE_TICKS) send_tick(random_tick());
            drain();
        end
        repeat (10) @(posedge clk);
        if (mix.pending() != 0)
        begin
            $error("%0d ticks still waiting for command items", mix.pending());
            mix.errors++;
        end
        if (mix.errors == 0)
            $display("three_axis_stick_pd_mixer_core test passed");
        else
            $display("three_axis_stick_pd_mixer_core test failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/tasp_pkg.sv
rtl/core/tasp_cfg_regs.sv
rtl/core/tasp_front_stage.sv
rtl/core/tasp_product_stage.sv
rtl/core/tasp_result_stage.sv
rtl/core/three_axis_stick_pd_mixer_core.sv
tb/three_axis_stick_pd_mixer_core_tb.sv
